>>> rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the 3x3 local binary pattern stream block.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int LINE_W_BITS   = 11;
    localparam int LINE_W_RESET  = 1024;
    localparam int MIN_WIDTH     = 3;
    localparam int PIX_BITS      = 8;

    localparam logic [1:0] ROW_FULL = 2'd2;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                frame_start;
    } t_in_item;

    typedef struct packed {
        logic [PIX_BITS-1:0] code;
        logic                row_last;
    } t_out_item;

    // Per-item flags handed from the column counter to the code stage
    typedef struct packed {
        logic has_code;
        logic row_last;
    } t_tap_ctl;

    function automatic logic [1:0] row_inc(input logic [1:0] row);
        row_inc = (row == ROW_FULL) ? row : row + 2'd1;
    endfunction

endpackage

>>> rtl/lbp_3x3_code_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_code_stream
// 3x3 local binary pattern codes over a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one code per clock for every interior
// pixel while the output keeps taking codes; border pixels give no code. A
// code is offered on the output once the pixel completing its window (the
// bottom-right neighbour) is taken: the line store is read on the accepting
// edge, and the compares load the output register once it is free.
// The rate is set by the line store, a single RAM of MAX_WIDTH words holding
// the two previous rows side by side, which takes one read and one write per
// pixel. Code bit 0 is the top-left neighbour, running clockwise to bit 7 on
// the left; a bit is set when that neighbour is strictly greater than the
// centre. line_width is clamped to 3..MAX_WIDTH; the user must write it only
// while no item is in flight, as the block does not enforce it. No clearing
// pass follows reset: a fresh frame writes a column before a code uses it.
// ----------------------------------------------------------------------------
module lbp_3x3_code_stream #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lbp_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lbp_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lbp_pkg::LINE_W_BITS-1:0] i_cfg_data
);

    import lbp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic              in_accept;
    logic [CW-1:0]     s_col;
    t_tap_ctl          s_ctl;
    logic              s_we;
    logic [CW-1:0]     s_waddr;
    logic [2*PIX_BITS-1:0] s_wdata;
    logic [2*PIX_BITS-1:0] s_rdata;

    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    lbp_addr_gen #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_addr_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_accept),
        .i_frame_start (i_in_data.frame_start),
        .o_col         (s_col),
        .o_ctl         (s_ctl)
    );

    // upper row in the high byte, middle row in the low byte
    lbp_ram #(
        .WIDTH (2 * PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (in_accept),
        .i_raddr (s_col),
        .o_rdata (s_rdata)
    );

    lbp_code_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_code_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_px        (i_in_data.pixel),
        .i_col       (s_col),
        .i_ctl       (s_ctl),
        .i_rd_data   (s_rdata),
        .o_we        (s_we),
        .o_waddr     (s_waddr),
        .o_wdata     (s_wdata),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_frame_start_no_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_data.frame_start |-> !s_ctl.has_code)
        else $error("frame start pixel flagged as completing a window");

    a_code_interior : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && s_ctl.has_code |-> s_col >= CW'(2))
        else $error("code flagged in a left border column");

    a_retire_frees_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> o_in_ready)
        else $error("line store write without the stage freeing up");

endmodule

>>> rtl/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lbp_addr_gen.sv
// ----------------------------------------------------------------------------
// lbp_addr_gen
// Line width register and column/row counters; picks the line store column
// of each incoming item and flags whether it completes an interior window.
// ----------------------------------------------------------------------------
module lbp_addr_gen #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int WW       = $clog2(MAX_WIDTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [lbp_pkg::LINE_W_BITS-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_frame_start,
    output logic [CW-1:0]                  o_col,
    output lbp_pkg::t_tap_ctl              o_ctl
);

    import lbp_pkg::*;

    localparam int CMPW  = (WW > LINE_W_BITS) ? WW : LINE_W_BITS;
    localparam int RST_W = (LINE_W_RESET > MAX_WIDTH) ? MAX_WIDTH :
                           (LINE_W_RESET < MIN_WIDTH) ? MIN_WIDTH : LINE_W_RESET;

    logic [WW-1:0]   r_width;
    logic [CW-1:0]   r_last_col;
    logic [CW-1:0]   r_col;
    logic [1:0]      r_row;

    logic [CMPW-1:0] cfg_ext;
    logic [CMPW-1:0] cfg_clamped;
    logic [CW-1:0]   cnt0;
    logic [1:0]      row0;
    logic [1:0]      row1;
    logic            wrap;
    logic            last;
    logic [CW-1:0]   col;
    logic [CW-1:0]   n_col;
    logic [1:0]      n_row;

    always_comb begin
        cfg_ext = CMPW'(i_cfg_data);
        if (cfg_ext < CMPW'(MIN_WIDTH)) begin
            cfg_clamped = CMPW'(MIN_WIDTH);
        end else if (cfg_ext > CMPW'(MAX_WIDTH)) begin
            cfg_clamped = CMPW'(MAX_WIDTH);
        end else begin
            cfg_clamped = cfg_ext;
        end
    end

    always_comb begin
        cnt0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : r_row;
        // a narrowed width can leave the count past the row end: wrap early
        wrap = WW'(cnt0) >= r_width;
        col  = wrap ? '0 : cnt0;
        row1 = wrap ? row_inc(row0) : row0;
        last = (col == r_last_col);
        n_col = last ? '0 : col + CW'(1);
        n_row = last ? row_inc(row1) : row1;
    end

    assign o_col          = col;
    assign o_ctl.has_code = (row1 == ROW_FULL) && (col >= CW'(2));
    assign o_ctl.row_last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(RST_W);
            r_last_col <= CW'(RST_W - 1);
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_width    <= WW'(cfg_clamped);
                r_last_col <= CW'(cfg_clamped - CMPW'(1));
            end
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

>>> rtl/lbp_code_unit.sv
// ----------------------------------------------------------------------------
// lbp_code_unit
// Read-modify-write stage for the line store, 3x3 window registers, the
// eight neighbour compares and the output register.
// ----------------------------------------------------------------------------
module lbp_code_unit #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int PW       = lbp_pkg::PIX_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [PW-1:0]       i_px,
    input  logic [CW-1:0]       i_col,
    input  lbp_pkg::t_tap_ctl   i_ctl,
    input  logic [2*PW-1:0]     i_rd_data,
    output logic                o_we,
    output logic [CW-1:0]       o_waddr,
    output logic [2*PW-1:0]     o_wdata,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lbp_pkg::t_out_item  o_out_data
);

    import lbp_pkg::*;

    logic            r_b_valid;
    logic [PW-1:0]   r_b_px;
    logic [CW-1:0]   r_b_col;
    t_tap_ctl        r_b_ctl;
    logic            r_fwd;
    logic [2*PW-1:0] r_fwd_data;
    logic [PW-1:0]   r_win [6];
    logic            r_out_valid;
    t_out_item       r_out;

    logic [2*PW-1:0] line_word;
    logic [PW-1:0]   top;
    logic [PW-1:0]   mid;
    logic [PW-1:0]   centre;
    logic [PW-1:0]   code;
    logic            out_free;
    logic            b_go;

    // the item ahead writes its column on the edge this one reads it
    assign line_word = r_fwd ? r_fwd_data : i_rd_data;
    assign top       = line_word[2*PW-1:PW];
    assign mid       = line_word[PW-1:0];
    assign centre    = r_win[4];

    always_comb begin
        code[0] = r_win[0] > centre;
        code[1] = r_win[3] > centre;
        code[2] = top      > centre;
        code[3] = mid      > centre;
        code[4] = r_b_px   > centre;
        code[5] = r_win[5] > centre;
        code[6] = r_win[2] > centre;
        code[7] = r_win[1] > centre;
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign b_go       = r_b_valid && (!r_b_ctl.has_code || out_free);
    assign o_in_ready = !r_b_valid || b_go;

    assign o_we    = b_go;
    assign o_waddr = r_b_col;
    assign o_wdata = {mid, r_b_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (b_go && r_b_ctl.has_code) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (b_go) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_b_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_px     <= i_px;
            r_b_col    <= i_col;
            r_b_ctl    <= i_ctl;
            r_fwd      <= b_go && (r_b_col == i_col);
            r_fwd_data <= {mid, r_b_px};
        end
        if (b_go && r_b_ctl.has_code) begin
            r_out.code     <= code;
            r_out.row_last <= r_b_ctl.row_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the 3x3 LBP code stream against a cycle-free predictor of its codes.
// ----------------------------------------------------------------------------
// Pixels go in over a valid/ready channel with random gaps. Every accepted
// pixel is run through a local copy of the line stores and window, and each
// code it produces is queued. A separate process takes the results with
// random stalls and compares code and row_last against the queue. The tests
// cover the stream from reset without a frame start, both ends of the width
// clamp, width changes inside a frame, frame restarts, a long output hold and
// random frames.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    localparam int RAND_ITEMS   = 180;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_item              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [LINE_W_BITS-1:0] i_cfg_data = '0;

    // predictor state
    logic [PIX_BITS-1:0]    upper_row [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_BITS-1:0]    middle_row [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_BITS-1:0]    win_cols [6] = '{default: '0};
    int                     col_pos = 0;
    int                     rows_seen = 0;
    logic [LINE_W_BITS-1:0] width_reg = LINE_W_BITS'(LINE_W_RESET);

    t_out_item              codes_due [$];
    int                     mismatches = 0;
    int                     quiet_cycles = 0;
    int                     hold_requests = 0;
    int                     src_calm = 0;
    bit                     src_gaps_off = 1'b0;

    lbp_3x3_code_stream u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH: %s", what);
        mismatches++;
    endtask

    // Mostly short gaps, a few long ones, now and then a run with none
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm = $urandom_range(16, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    // Bias toward extremes and near-equal values so ties show up often
    function automatic logic [PIX_BITS-1:0] draw_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return PIX_BITS'($urandom_range(0, 255));
        if (r < 7) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return PIX_BITS'(100 + $urandom_range(0, 2));
    endfunction

    function automatic void predict_code(input t_in_item item);
        int                  w;
        int                  c;
        logic [PIX_BITS-1:0] top;
        logic [PIX_BITS-1:0] mid;
        logic [PIX_BITS-1:0] ctr;
        t_out_item           res;
        w = int'(width_reg);
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (item.frame_start) begin
            col_pos = 0;
            rows_seen = 0;
        end
        // width shrank below the current column: close the row
        if (col_pos >= w) begin
            col_pos = 0;
            if (rows_seen < 2) rows_seen++;
        end
        c = col_pos;
        top = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = item.pixel;
        if (rows_seen >= 2 && c >= 2) begin
            ctr = win_cols[4];
            res.code = {win_cols[1] > ctr, win_cols[2] > ctr, win_cols[5] > ctr,
                        item.pixel > ctr, mid > ctr, top > ctr,
                        win_cols[3] > ctr, win_cols[0] > ctr};
            res.row_last = (c == w - 1);
            codes_due = {codes_due, res};
        end
        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = top;
        win_cols[4] = mid;
        win_cols[5] = item.pixel;
        if (c == w - 1) begin
            col_pos = 0;
            if (rows_seen < 2) rows_seen++;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // Called and left at a falling edge; valid stays high between back-to-back items
    task automatic push_pixel(input logic [PIX_BITS-1:0] px, input logic fs);
        int       gap;
        t_in_item item;
        gap = src_gaps_off ? 0 : draw_gap(src_calm);
        item.pixel = px;
        item.frame_start = fs;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_code(item);
        @(negedge i_clk);
    endtask

    task automatic push_random(input int count, input logic fs_first);
        for (int i = 0; i < count; i++) begin
            push_pixel(draw_pixel(), fs_first && i == 0);
        end
    endtask

    // Drop valid, let every due code come out, then give the pipe time to empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (codes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_width(input logic [LINE_W_BITS-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        width_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One 3x3 frame: a single code for the centre
    task automatic push_patch(input logic [PIX_BITS-1:0] centre,
                              input logic [PIX_BITS-1:0] ring);
        for (int i = 0; i < 9; i++) begin
            push_pixel((i == 4) ? centre : ring, i == 0);
        end
    endtask

    // Reset width, no frame start: the stream counts as a frame begun at reset.
    // Narrow to the column already reached so the row closes, then run on.
    task automatic test_stream_from_reset();
        push_random(40, 1'b0);
        write_width(LINE_W_BITS'(40));
        push_random(3 * 40, 1'b0);
    endtask

    task automatic test_width_low_clamp();
        write_width('0);
        push_patch(8'h00, 8'hFF);
        write_width(LINE_W_BITS'(2));
        push_patch(8'h07, 8'h07);
        write_width(LINE_W_BITS'(MIN_WIDTH));
        push_patch(8'hFF, 8'h00);
    endtask

    task automatic test_width_high_clamp();
        write_width('1);
        push_random(40, 1'b1);
    endtask

    task automatic test_width_change_mid_frame();
        write_width(LINE_W_BITS'(10));
        push_random(3 * 10 + 6, 1'b1);
        // narrow below the current column, then widen past it
        write_width(LINE_W_BITS'(5));
        push_random(2 * 5 + 2, 1'b0);
        write_width(LINE_W_BITS'(40));
        push_random(38 + 40, 1'b0);
    endtask

    task automatic test_frame_restart();
        write_width(LINE_W_BITS'(6));
        push_random(3 * 6 + 4, 1'b1);
        push_random(4 * 6, 1'b1);
    endtask

    // Hold results off while pixels keep coming, so the input backs up
    task automatic test_output_hold();
        write_width(LINE_W_BITS'(5));
        hold_requests++;
        src_gaps_off = 1'b1;
        push_random(5 * 12, 1'b1);
        src_gaps_off = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int sent;
        int w;
        int r;
        int n;
        bit cont;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) w = $urandom_range(3, 12);
            else w = $urandom_range(13, 40);
            if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 2);
            cont = ($urandom_range(0, 9) == 0);
            write_width(LINE_W_BITS'(w));
            if (w < MIN_WIDTH) w = MIN_WIDTH;
            n = $urandom_range(3, 8) * w;
            // cut some frames short
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
            if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
            for (int i = 0; i < n; i++) begin
                push_pixel(draw_pixel(),
                           (i == 0 && !cont) || ($urandom_range(0, 199) == 0));
            end
            sent += n;
        end
    endtask

    initial begin : result_sink
        t_out_item got;
        t_out_item want;
        int        stall_left;
        int        hold_left;
        int        hold_served;
        int        snk_calm;
        stall_left = 0;
        hold_left = 0;
        hold_served = 0;
        snk_calm = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (codes_due.size() == 0) begin
                    flag_mismatch($sformatf("code %02h with none due", got.code));
                end else begin
                    want = codes_due.pop_front();
                    if (got.code !== want.code) begin
                        flag_mismatch($sformatf("code %02h, want %02h",
                                                got.code, want.code));
                    end
                    if (got.row_last !== want.row_last) begin
                        flag_mismatch($sformatf("row_last %b, want %b (code %02h)",
                                                got.row_last, want.row_last,
                                                want.code));
                    end
                end
                stall_left = draw_gap(snk_calm);
            end
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_stream_from_reset();
        test_width_low_clamp();
        test_width_high_clamp();
        test_width_change_mid_frame();
        test_frame_restart();
        test_output_hold();
        test_random_frames();
        wait_idle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
